/* src/m3i_pkg.sv */
// Shared types, widths and index tables for the 3x3 fixed-point matrix inverse.
// Used by the channel interfaces, the front end, the divider lanes and the top level.
// No dependencies.
package m3i_pkg;

  // element format: signed Q16.16
  localparam int unsigned ElemW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ThrW     = 31;

  // exact widths of the intermediate values
  localparam int unsigned AdjW = 2 * ElemW + 1;        // one 2x2 cofactor
  localparam int unsigned DetW = 3 * ElemW + 3;        // determinant
  localparam int unsigned NumW = AdjW + 2 * FracBits;  // scaled cofactor magnitude
  localparam int unsigned CmpW = DetW + ElemW;         // divisor shifted by up to ElemW

  // pipeline depths
  localparam int unsigned FrontLat = 6;
  localparam int unsigned LaneLat  = ElemW + 2;
  localparam int unsigned TotLat   = FrontLat + LaneLat;

  typedef logic signed [ElemW-1:0]     elem_t;
  typedef logic signed [AdjW-1:0]      adj_t;
  typedef logic signed [2*ElemW-1:0]   prod_t;
  typedef logic signed [DetW-1:0]      det_t;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusSingular = 2'd1,
    StatusSat      = 2'd2
  } status_e;

  // control handed from the front end to the lanes and the merge stage
  typedef struct packed {
    logic [DetW-1:0] absdet;
    logic            det_neg;
    logic            sing;
  } front_ctl_t;

  // adjugate element k = e[a]*e[b] - e[c]*e[d], row-major element indexes
  localparam int unsigned CofIdx [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // first-row expansion: det = sum e[r] * adj[DetIdx[r]]
  localparam int unsigned DetIdx [3] = '{0, 3, 6};

endpackage

/* src/m3i_if.sv */
// Request and result channels of the matrix inverse: valid/ready plus payload.
// Depends on m3i_pkg.
interface m3i_in_if import m3i_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t e00, e01, e02, e10, e11, e12, e20, e21, e22;

  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  input ready);
  modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  output ready);
endinterface

interface m3i_out_if import m3i_pkg::*; ();
  logic       valid;
  logic       ready;
  elem_t      i00, i01, i02, i10, i11, i12, i20, i21, i22;
  logic [1:0] status;

  modport source (output valid, i00, i01, i02, i10, i11, i12, i20, i21, i22, status,
                  input ready);
  modport sink   (input valid, i00, i01, i02, i10, i11, i12, i20, i21, i22, status,
                  output ready);
endinterface

/* src/m3i_front.sv */
// Front end: nine exact cofactors, first-row determinant, magnitude and singular test.
// Six register stages, all advancing on en_i. Depends on m3i_pkg.
module m3i_front import m3i_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [ThrW-1:0] thr_i,
  input  elem_t           elem_i [9],
  output adj_t            adj_o  [9],
  output front_ctl_t      ctl_o
);

  prod_t      pa_q [9];
  prod_t      pb_q [9];
  elem_t      ea_q [3];
  adj_t       adj_b_q [9];
  elem_t      eb_q [3];
  adj_t       lo_q [3];
  adj_t       hi_q [3];
  adj_t       adj_c_q [9];
  det_t       t_q [3];
  adj_t       adj_d_q [9];
  det_t       det_q;
  adj_t       adj_e_q [9];
  adj_t       adj_f_q [9];
  front_ctl_t ctl_q;
  logic [DetW-1:0] absdet;

  // products of the cofactor pairs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= elem_i[CofIdx[k][0]] * elem_i[CofIdx[k][1]];
        pb_q[k] <= elem_i[CofIdx[k][2]] * elem_i[CofIdx[k][3]];
      end
      for (int r = 0; r < 3; r++) begin
        ea_q[r] <= elem_i[r];
      end
    end
  end

  // cofactor differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        adj_b_q[k] <= AdjW'(pa_q[k]) - AdjW'(pb_q[k]);
      end
      eb_q <= ea_q;
    end
  end

  // determinant partial products, cofactor split into low and high halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        lo_q[r] <= eb_q[r] * $signed({1'b0, adj_b_q[DetIdx[r]][ElemW-1:0]});
        hi_q[r] <= eb_q[r] * $signed(adj_b_q[DetIdx[r]][AdjW-1:ElemW]);
      end
      adj_c_q <= adj_b_q;
    end
  end

  // recombine halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        t_q[r] <= (DetW'(hi_q[r]) <<< ElemW) + DetW'(lo_q[r]);
      end
      adj_d_q <= adj_c_q;
    end
  end

  // sum the three terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q   <= t_q[0] + t_q[1] + t_q[2];
      adj_e_q <= adj_d_q;
    end
  end

  // magnitude and threshold compare at full precision
  assign absdet = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q.absdet  <= absdet;
      ctl_q.det_neg <= det_q[DetW-1];
      ctl_q.sing    <= absdet <= (DetW'(thr_i) << (2 * FracBits));
      adj_f_q       <= adj_e_q;
    end
  end

  assign adj_o = adj_f_q;
  assign ctl_o = ctl_q;

endmodule

/* src/m3i_div_lane.sv */
// One divider lane: scaled cofactor over |det|, one quotient bit per stage,
// truncation toward zero and saturation. Depends on m3i_pkg.
module m3i_div_lane import m3i_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  adj_t            adj_i,
  input  logic [DetW-1:0] absdet_i,
  input  logic            det_neg_i,
  output elem_t           quo_o,
  output logic            sat_o
);

  logic [NumW-1:0]  rem_q [ElemW+1];
  logic [DetW-1:0]  dv_q  [ElemW+1];
  logic [ElemW-1:0] q_q   [ElemW+1];
  logic             neg_q [ElemW+1];
  logic             ovf_q [ElemW+1];

  logic [AdjW-1:0]  mag;
  logic [NumW-1:0]  num;
  logic [ElemW-1:0] qf;
  logic             negf, ovff, psat, nsat;
  elem_t            quo_q;
  logic             sat_q;

  // magnitude, sign and overflow precheck (quotient at or above 2^ElemW)
  assign mag = adj_i[AdjW-1] ? AdjW'(-adj_i) : AdjW'(adj_i);
  assign num = {mag, {(2 * FracBits){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num;
      dv_q[0]  <= absdet_i;
      q_q[0]   <= '0;
      neg_q[0] <= adj_i[AdjW-1] ^ det_neg_i;
      ovf_q[0] <= CmpW'(num) >= (CmpW'(absdet_i) << ElemW);
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar j = 1; j <= ElemW; j++) begin : g_step
    localparam int unsigned Sh = ElemW - j;
    logic [CmpW-1:0] sub;
    logic [CmpW-1:0] diff;
    logic            ge;

    assign sub  = CmpW'(dv_q[j-1]) << Sh;
    assign ge   = CmpW'(rem_q[j-1]) >= sub;
    assign diff = CmpW'(rem_q[j-1]) - sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? diff[NumW-1:0] : rem_q[j-1];
        q_q[j]   <= {q_q[j-1][ElemW-2:0], ge};
        dv_q[j]  <= dv_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // apply sign and saturate to the element range
  assign qf   = q_q[ElemW];
  assign negf = neg_q[ElemW];
  assign ovff = ovf_q[ElemW];
  assign psat = !negf && (ovff || qf[ElemW-1]);
  assign nsat = negf && (ovff || (qf[ElemW-1] && (|qf[ElemW-2:0])));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (psat) begin
        quo_q <= {1'b0, {(ElemW-1){1'b1}}};
      end else if (nsat) begin
        quo_q <= {1'b1, {(ElemW-1){1'b0}}};
      end else begin
        quo_q <= negf ? $signed(-qf) : $signed(qf);
      end
      sat_q <= psat || nsat;
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;

endmodule

/* src/matrix3x3_inverse.sv */
// 3x3 fixed-point matrix inverse (adjugate over determinant), Q16.16 in and out.
// Pipeline: 6 front-end stages for cofactors and determinant, then 34 stages in each
// divider lane, one quotient bit per stage.
// Throughput: one matrix per cycle; the whole pipeline holds only while a result waits.
// Reset: rst_ni clears the pipeline valid bits and the singular threshold (to 0).
// Depends on m3i_pkg, m3i_if, m3i_front, m3i_div_lane.
module matrix3x3_inverse import m3i_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  m3i_in_if.sink          in_i,
  m3i_out_if.source       out_o
);

  logic [ThrW-1:0]    thr_q;
  logic [TotLat-1:0]  vld_q;
  logic [LaneLat-1:0] sng_q;
  logic               en;
  logic               sng;
  logic [8:0]         sat;
  elem_t              elem [9];
  adj_t               adj  [9];
  elem_t              quo  [9];
  elem_t              res  [9];
  front_ctl_t         ctl;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // advance everything unless the output holds an untaken result
  assign en       = !vld_q[TotLat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sng_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotLat-2:0], in_i.valid};
      sng_q <= {sng_q[LaneLat-2:0], ctl.sing};
    end
  end

  assign elem[0] = in_i.e00;
  assign elem[1] = in_i.e01;
  assign elem[2] = in_i.e02;
  assign elem[3] = in_i.e10;
  assign elem[4] = in_i.e11;
  assign elem[5] = in_i.e12;
  assign elem[6] = in_i.e20;
  assign elem[7] = in_i.e21;
  assign elem[8] = in_i.e22;

  m3i_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .thr_i  (thr_q),
    .elem_i (elem),
    .adj_o  (adj),
    .ctl_o  (ctl)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .adj_i     (adj[k]),
      .absdet_i  (ctl.absdet),
      .det_neg_i (ctl.det_neg),
      .quo_o     (quo[k]),
      .sat_o     (sat[k])
    );
  end

  // merge lanes: singular forces zeros and the singular status, else any saturation flags the status
  assign sng = sng_q[LaneLat-1];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      res[k] = sng ? '0 : quo[k];
    end
  end

  assign out_o.valid  = vld_q[TotLat-1];
  assign out_o.status = sng ? StatusSingular : ((|sat) ? StatusSat : StatusOk);
  assign out_o.i00 = res[0];
  assign out_o.i01 = res[1];
  assign out_o.i02 = res[2];
  assign out_o.i10 = res[3];
  assign out_o.i11 = res[4];
  assign out_o.i12 = res[5];
  assign out_o.i20 = res[6];
  assign out_o.i21 = res[7];
  assign out_o.i22 = res[8];

endmodule

/* src/m3i_chk.sv */
// Port-level checks for the matrix inverse, attached to the top level by bind.
// Depends on m3i_pkg and matrix3x3_inverse.
module m3i_chk import m3i_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [1:0]           status_i,
  input logic [9*ElemW-1:0]   res_i
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(res_i))
    else $error("stalled result changed");

  // accept requests whenever the output is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request refused with empty output");

  // singular results carry zero elements
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == StatusSingular |-> res_i == '0)
    else $error("singular result with nonzero elements");

  // status code stays within its three values
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == StatusOk || status_i == StatusSingular ||
                    status_i == StatusSat)
    else $error("bad status code");

endmodule

bind matrix3x3_inverse m3i_chk u_m3i_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .res_i       ({out_o.i00, out_o.i01, out_o.i02, out_o.i10, out_o.i11,
                 out_o.i12, out_o.i20, out_o.i21, out_o.i22})
);

/* bench/tb_top.sv */
// Testbench for matrix3x3_inverse: a directed table and then random matrices, each result
// checked against the table's expected inverse or a bit-exact predictor held in this file.
// Depends on m3i_pkg, m3i_if and the matrix3x3_inverse RTL.
`timescale 1ns / 100ps

module tb_top;
  import m3i_pkg::*;

  typedef elem_t mat_t [9];
  typedef struct {
    elem_t   v [9];
    status_e st;
  } inv_t;
  typedef struct {
    mat_t m;
    bit   typed;
    inv_t r;
  } row_t;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = TotLat + 8;
  localparam int unsigned RandItems     = 1650;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [ThrW-1:0] cfg_wdata;
  logic [ThrW-1:0] thr_model;

  m3i_in_if  req_ch ();
  m3i_out_if res_ch ();

  matrix3x3_inverse i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req_ch),
    .out_o      (res_ch)
  );

  inv_t    inv_q [$];
  row_t    table_q [$];
  bit      typed_q [$];
  inv_t    typed_r_q [$];
  int      snd_idle, rcv_idle;
  int      mismatches, n_results, n_singular, n_sat, n_req, idle_cycles;

  // clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // predict the inverse of one matrix under the current threshold
  function automatic inv_t inverse_of(mat_t m, logic [ThrW-1:0] thr);
    logic signed [127:0] e [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det, num;
    logic [127:0] absdet, mag, quo, lim, thr_w;
    bit   neg;
    inv_t r;
    r.st = StatusOk;
    for (int k = 0; k < 9; k++) e[k] = m[k];
    for (int k = 0; k < 9; k++) begin
      adj[k] = e[CofIdx[k][0]] * e[CofIdx[k][1]] - e[CofIdx[k][2]] * e[CofIdx[k][3]];
    end
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    absdet = det[127] ? -det : det;
    thr_w = {97'd0, thr} << (2 * FracBits);
    if (absdet <= thr_w) begin
      for (int k = 0; k < 9; k++) r.v[k] = '0;
      r.st = StatusSingular;
      return r;
    end
    lim = 128'd1 << (ElemW - 1);
    for (int k = 0; k < 9; k++) begin
      num = adj[k] <<< (2 * FracBits);
      neg = num[127] != det[127];
      mag = num[127] ? -num : num;
      quo = mag / absdet;
      if (!neg && quo >= lim) begin
        r.v[k] = 32'h7FFF_FFFF;
        r.st = StatusSat;
      end else if (neg && quo > lim) begin
        r.v[k] = 32'h8000_0000;
        r.st = StatusSat;
      end else begin
        r.v[k] = neg ? -quo[31:0] : quo[31:0];
      end
    end
    return r;
  endfunction

  // random matrix of one of several shapes
  function automatic mat_t rand_matrix();
    mat_t m;
    int   kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1: begin
          m[k] = $urandom;
        end
        2, 3, 4: begin
          m[k] = $signed($urandom_range(0, 1048576)) - 524288;
        end
        5: begin
          m[k] = (k % 4 == 0) ? $signed($urandom_range(1, 4096)) : 0;
          if ($urandom_range(0, 1)) m[k] = -m[k];
        end
        6: begin
          case ($urandom_range(0, 3))
            0: m[k] = 0;
            1: m[k] = 32'h8000_0000;
            2: m[k] = 32'h7FFF_FFFF;
            default: m[k] = $urandom;
          endcase
        end
        default: begin
          m[k] = $signed($urandom_range(0, 65536)) - 32768;
        end
      endcase
    end
    // make row 2 the sum of rows 0 and 1 (kind 7) or row 1 a copy of row 0 (kind 8) for a singular matrix
    if (kind == 7) for (int c = 0; c < 3; c++) m[6 + c] = m[c] + m[3 + c];
    if (kind == 8) for (int c = 0; c < 3; c++) m[3 + c] = m[c];
    return m;
  endfunction

  function automatic inv_t diag_inv(elem_t d, status_e st);
    inv_t r;
    for (int k = 0; k < 9; k++) r.v[k] = (k % 4 == 0) ? d : '0;
    r.st = st;
    return r;
  endfunction

  function automatic mat_t diag_mat(elem_t d);
    mat_t m;
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? d : '0;
    return m;
  endfunction

  task automatic add_row(mat_t m, bit typed, inv_t r);
    row_t x;
    x.m = m;
    x.typed = typed;
    x.r = r;
    table_q.push_back(x);
  endtask

  // send one request, honoring the sender idle rate
  task automatic send_mat(mat_t m, bit typed, inv_t r);
    while ($urandom_range(0, 99) < snd_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    {req_ch.e00, req_ch.e01, req_ch.e02} = {m[0], m[1], m[2]};
    {req_ch.e10, req_ch.e11, req_ch.e12} = {m[3], m[4], m[5]};
    {req_ch.e20, req_ch.e21, req_ch.e22} = {m[6], m[7], m[8]};
    typed_q.push_back(typed);
    typed_r_q.push_back(r);
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // hold until every expected result is in, then let the pipeline settle
  task automatic drain();
    req_ch.valid = 1'b0;
    while (inv_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_thr(logic [ThrW-1:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = val;
    thr_model = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // receiver: drop ready at the configured rate
  always @(negedge clk_i) begin
    if (rst_ni) res_ch.ready = ($urandom_range(0, 99) >= rcv_idle);
  end

  // record accepted requests with their expected inverse
  always @(posedge clk_i) begin
    inv_t r;
    bit   typed;
    mat_t m;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      m = '{req_ch.e00, req_ch.e01, req_ch.e02, req_ch.e10, req_ch.e11,
            req_ch.e12, req_ch.e20, req_ch.e21, req_ch.e22};
      typed = typed_q.pop_front();
      r = typed_r_q.pop_front();
      inv_q.push_back(typed ? r : inverse_of(m, thr_model));
      n_req++;
    end
  end

  // check accepted results against the oldest expectation
  always @(posedge clk_i) begin
    inv_t exp_r;
    elem_t got [9];
    bit   bad;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.i00, res_ch.i01, res_ch.i02, res_ch.i10, res_ch.i11,
              res_ch.i12, res_ch.i20, res_ch.i21, res_ch.i22};
      n_results++;
      if (inv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request pending");
      end else begin
        exp_r = inv_q.pop_front();
        bad = (res_ch.status !== exp_r.st);
        for (int k = 0; k < 9; k++) if (got[k] !== exp_r.v[k]) bad = 1'b1;
        if (res_ch.status == StatusSingular) n_singular++;
        if (res_ch.status == StatusSat) n_sat++;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d status exp %0d got %0d", n_results, exp_r.st,
                     res_ch.status);
            for (int k = 0; k < 9; k++) begin
              $display("  i%0d%0d exp %h got %h", k / 3, k % 3, exp_r.v[k], got[k]);
            end
          end
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mat_t m;
    inv_t none;
    none = diag_inv('0, StatusOk);
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    thr_model = '0;
    req_ch.valid = 1'b0;
    {req_ch.e00, req_ch.e01, req_ch.e02, req_ch.e10, req_ch.e11} = '0;
    {req_ch.e12, req_ch.e20, req_ch.e21, req_ch.e22} = '0;
    res_ch.ready = 1'b0;
    snd_idle = 24;
    rcv_idle = 68;
    mismatches = 0;
    n_results = 0;
    n_singular = 0;
    n_sat = 0;
    n_req = 0;
    idle_cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: threshold is still the reset value of zero
    add_row(diag_mat(0), 1, diag_inv(0, StatusSingular));
    add_row(diag_mat(32'h0001_0000), 1, diag_inv(32'h0001_0000, StatusOk));
    add_row(diag_mat(32'h0002_0000), 1, diag_inv(32'h0000_8000, StatusOk));
    add_row(diag_mat(-32'sh0001_0000), 1, diag_inv(-32'sh0001_0000, StatusOk));
    add_row(diag_mat(1), 1, diag_inv(32'h7FFF_FFFF, StatusSat));
    add_row(diag_mat(-1), 1, diag_inv(32'h8000_0000, StatusSat));
    for (int k = 0; k < 9; k++) m[k] = 32'h7FFF_FFFF;
    add_row(m, 1, diag_inv(0, StatusSingular));
    for (int k = 0; k < 9; k++) m[k] = 32'h8000_0000;
    add_row(m, 1, diag_inv(0, StatusSingular));
    add_row(diag_mat(32'h8000_0000), 0, none);
    add_row(diag_mat(32'h7FFF_FFFF), 0, none);
    m = '{0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0};
    add_row(m, 0, none);
    m = '{32'h8000_0000, 32'h7FFF_FFFF, 1, -1, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, -1, 32'h8000_0000};
    add_row(m, 0, none);
    m = '{32'h0003_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0002_0000,
          32'h0001_0000, 0, 32'h0001_0000, 32'h0004_0000};
    add_row(m, 0, none);
    m = '{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
          32'h3333_3333, 32'hCCCC_CCCC, 32'h0000_FFFF, 32'hFFFF_0000};
    add_row(m, 0, none);
    foreach (table_q[i]) send_mat(table_q[i].m, table_q[i].typed, table_q[i].r);

    // threshold extremes with the same directed rows, checked by prediction
    write_thr({ThrW{1'b1}});
    foreach (table_q[i]) send_mat(table_q[i].m, 0, none);
    write_thr(ThrW'(1));
    foreach (table_q[i]) send_mat(table_q[i].m, 0, none);

    // random phases: three idle patterns, several thresholds
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_thr('0);
        1: write_thr(ThrW'($urandom_range(1, 16)));
        2: write_thr(ThrW'($urandom_range(0, 255)));
        3: write_thr({ThrW{1'b1}});
        4: write_thr(ThrW'($urandom));
        default: write_thr(ThrW'($urandom_range(0, 3)));
      endcase
      snd_idle = (ph < 2) ? 24 : (ph < 4) ? 68 : 0;
      rcv_idle = (ph < 2) ? 68 : (ph < 4) ? 24 : 0;
      for (int n = 0; n < RandItems / 6; n++) send_mat(rand_matrix(), 0, none);
    end

    // final drain with a bound
    req_ch.valid = 1'b0;
    while (inv_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("Covered %0d requests and %0d results: %0d singular, %0d saturated.",
             n_req, n_results, n_singular, n_sat);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && inv_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
